// ----- hdl/proximity_steering_controller_defines.svh -----
// Assertion macros shared by the proximity steering controller modules.
// No dependencies; included by the files that carry assertions.
`ifndef PROXIMITY_STEERING_CONTROLLER_DEFINES_SVH
`define PROXIMITY_STEERING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/psc_pkg.sv -----
// Shared types and constants for the proximity steering controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package psc_pkg;

  localparam int NumSensors = 8;
  localparam int ProxW      = 12;
  localparam int BiasW      = 10;
  localparam int LimitW     = 10;
  localparam int BeatW      = 24;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 24;

  typedef logic [ProxW-1:0]                 prox_t;
  typedef logic [NumSensors-1:0][ProxW-1:0] prox_arr_t;
  typedef logic signed [10:0]               speed_t;
  // Wide enough for decayed speed + bias + all steering weights.
  typedef logic signed [12:0]               sum_t;
  typedef logic [BeatW-1:0]                 beat_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegNearThr   = 3'd0,
    RegEscapeThr = 3'd1,
    RegBias      = 3'd2,
    RegLimit     = 3'd3,
    RegInterval  = 3'd4,
    RegWeight    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    prox_t              near_thr;
    prox_t              escape_thr;
    logic [BiasW-1:0]   bias;
    logic [LimitW-1:0]  limit;
    beat_t              interval;
    beat_t              interval_40;  // floor(interval*2/5)
    beat_t              interval_60;  // floor(interval*3/5)
    beat_t              weight;
  } cfg_t;

  // Register reset values
  localparam prox_t             NearThrRst   = 12'd500;
  localparam prox_t             EscapeThrRst = 12'd1900;
  localparam logic [BiasW-1:0]  BiasRst      = 10'd38;
  localparam logic [LimitW-1:0] LimitRst     = 10'd800;
  localparam beat_t             IntervalRst  = 24'd200000;
  localparam beat_t             Interval40Rst = 24'd80000;
  localparam beat_t             Interval60Rst = 24'd120000;
  localparam beat_t             WeightRst    = 24'd40000;

  // Front readings that shorten the heartbeat period
  localparam prox_t FrontHigh = 12'd900;
  localparam prox_t FrontLow  = 12'd300;

  // Forced spin magnitude
  localparam speed_t SpinSpeed = 11'sd200;

  // Per-sensor steering weights
  localparam speed_t SteerLeft [NumSensors] =
    '{11'sd300, 11'sd100, 11'sd300, 11'sd400, 11'sd400, -11'sd400, -11'sd100, 11'sd300};
  localparam speed_t SteerRight [NumSensors] =
    '{11'sd100, -11'sd100, -11'sd400, -11'sd300, -11'sd300, 11'sd300, 11'sd100, 11'sd100};

endpackage

// ----- hdl/proximity_steering_controller.sv -----
// Top level of the proximity steering controller: input register, result register,
// handshake control. Depends on psc_pkg, psc_cfg_regs, psc_steer, psc_beat, macro header.
`timescale 1ns / 1ps
`include "proximity_steering_controller_defines.svh"

//  channel   direction  handshake                  payload
//  in        sink       in_valid_i / in_stall_o    prox_0_i .. prox_7_i
//  out       source     out_valid_o / out_stall_i  left/right_speed_o, leds_on_o, escape_turn_o
//  cfg       sink       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
//  Items go through the input and result registers; one per cycle while out_stall_i is low.
//  The wheel and heartbeat state update as an item moves from the input register
//  into the result register, so each tick sees the state its predecessor left.
//  Reset clears control and state at once; no clearing pass is needed.
//  A stalled result holds the input register; in_stall_o rises only when both are full
//  and out_stall_i is high.

module proximity_steering_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [11:0]                   prox_0_i,
  input  logic [11:0]                   prox_1_i,
  input  logic [11:0]                   prox_2_i,
  input  logic [11:0]                   prox_3_i,
  input  logic [11:0]                   prox_4_i,
  input  logic [11:0]                   prox_5_i,
  input  logic [11:0]                   prox_6_i,
  input  logic [11:0]                   prox_7_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [10:0]            left_speed_o,
  output logic signed [10:0]            right_speed_o,
  output logic                          leds_on_o,
  output logic                          escape_turn_o,
  input  logic                          cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [psc_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  psc_pkg::cfg_t      cfg;
  psc_pkg::prox_arr_t prox_q;
  logic               in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic               accept, advance;
  psc_pkg::speed_t    left_nx, right_nx, left_q, right_q, left_wheel;
  logic               escape_nx, escape_q, led_nx, led_q;

  // Move the held item forward when the result register is empty or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prox_q <= {prox_7_i, prox_6_i, prox_5_i, prox_4_i,
                 prox_3_i, prox_2_i, prox_1_i, prox_0_i};
    end
    if (advance) begin
      left_q   <= left_nx;
      right_q  <= right_nx;
      escape_q <= escape_nx;
      led_q    <= led_nx;
    end
  end

  psc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  psc_steer u_steer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .prox_i       (prox_q),
    .cfg_i        (cfg),
    .left_o       (left_nx),
    .right_o      (right_nx),
    .escape_o     (escape_nx),
    .left_wheel_o (left_wheel)
  );

  psc_beat u_beat (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .front_left_i  (prox_q[0]),
    .front_right_i (prox_q[psc_pkg::NumSensors-1]),
    .cfg_i         (cfg),
    .led_o         (led_nx)
  );

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign leds_on_o     = led_q;
  assign escape_turn_o = escape_q;

  `PSC_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, in_valid_q && out_valid_q, "input stalled while a register was free")
  `PSC_ASSERT_NXT(a_free_output_fills, clk_i, rst_ni, in_valid_q && !out_valid_q, out_valid_q, "held item did not reach an empty result register")
  `PSC_ASSERT_IMP(a_result_matches_state, clk_i, rst_ni, out_valid_q, left_q == left_wheel, "pending left speed differs from the wheel state")

endmodule

// ----- hdl/psc_cfg_regs.sv -----
// Configuration registers and the pre-scaled heartbeat periods.
// Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [psc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output psc_pkg::cfg_t                     cfg_o
);

  // ceil(2^28 / 5): exact floor(x/5) for x below 2^26
  localparam logic [25:0] RecipFive = 26'd53687092;

  psc_pkg::cfg_t cfg_q, cfg_d;
  logic [25:0]   x2, x3;
  logic [51:0]   p2, p3;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (psc_pkg::cfg_idx_e'(cfg_idx_i))
        psc_pkg::RegNearThr:   cfg_d.near_thr   = cfg_wdata_i[psc_pkg::ProxW-1:0];
        psc_pkg::RegEscapeThr: cfg_d.escape_thr = cfg_wdata_i[psc_pkg::ProxW-1:0];
        psc_pkg::RegBias:      cfg_d.bias       = cfg_wdata_i[psc_pkg::BiasW-1:0];
        psc_pkg::RegLimit:     cfg_d.limit      = cfg_wdata_i[psc_pkg::LimitW-1:0];
        psc_pkg::RegInterval:  cfg_d.interval   = cfg_wdata_i[psc_pkg::BeatW-1:0];
        psc_pkg::RegWeight:    cfg_d.weight     = cfg_wdata_i[psc_pkg::BeatW-1:0];
        default: ;
      endcase
    end
    // Scaled periods load on the same edge as the interval they come from.
    x2 = {1'b0, cfg_d.interval, 1'b0};
    x3 = x2 + 26'(cfg_d.interval);
    p2 = 52'(x2) * 52'(RecipFive);
    p3 = 52'(x3) * 52'(RecipFive);
    cfg_d.interval_40 = p2[51:28];
    cfg_d.interval_60 = p3[51:28];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_thr    <= psc_pkg::NearThrRst;
      cfg_q.escape_thr  <= psc_pkg::EscapeThrRst;
      cfg_q.bias        <= psc_pkg::BiasRst;
      cfg_q.limit       <= psc_pkg::LimitRst;
      cfg_q.interval    <= psc_pkg::IntervalRst;
      cfg_q.interval_40 <= psc_pkg::Interval40Rst;
      cfg_q.interval_60 <= psc_pkg::Interval60Rst;
      cfg_q.weight      <= psc_pkg::WeightRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/psc_steer.sv -----
// Wheel speed datapath: decay, bias, steering weights, escape spin, clamp.
// Holds the wheel speed state. Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_steer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  psc_pkg::prox_arr_t  prox_i,
  input  psc_pkg::cfg_t       cfg_i,
  output psc_pkg::speed_t     left_o,
  output psc_pkg::speed_t     right_o,
  output logic                escape_o,
  output psc_pkg::speed_t     left_wheel_o
);

  // ceil(2^19 / 10): exact floor(x/10) for x below 2^18
  localparam logic [29:0] RecipTen = 30'd52429;

  psc_pkg::speed_t left_q, right_q, left_d, right_d;
  psc_pkg::sum_t   left_sum, right_sum, lim, left_c, right_c;

  // trunc(v*9/10), rounding toward zero
  function automatic psc_pkg::sum_t decay(psc_pkg::speed_t v);
    logic        neg;
    logic [10:0] mag;
    logic [13:0] m9;
    logic [29:0] prod;
    logic [9:0]  q;
    neg  = v[10];
    mag  = neg ? 11'(-v) : 11'(v);
    m9   = 14'(mag) * 14'd9;
    prod = 30'(m9) * RecipTen;
    q    = prod[28:19];
    decay = neg ? -psc_pkg::sum_t'({3'b000, q}) : psc_pkg::sum_t'({3'b000, q});
  endfunction

  always_comb begin
    left_sum  = decay(left_q)  + psc_pkg::sum_t'({3'b000, cfg_i.bias});
    right_sum = decay(right_q) + psc_pkg::sum_t'({3'b000, cfg_i.bias});
    for (int k = 0; k < psc_pkg::NumSensors; k++) begin
      if (prox_i[k] >= cfg_i.near_thr) begin
        left_sum  = left_sum  + psc_pkg::sum_t'(psc_pkg::SteerLeft[k]);
        right_sum = right_sum + psc_pkg::sum_t'(psc_pkg::SteerRight[k]);
      end
    end

    // Right front overrides left front.
    escape_o = 1'b0;
    if (prox_i[0] > cfg_i.escape_thr) begin
      left_sum  = psc_pkg::sum_t'(psc_pkg::SpinSpeed);
      right_sum = -psc_pkg::sum_t'(psc_pkg::SpinSpeed);
      escape_o  = 1'b1;
    end
    if (prox_i[psc_pkg::NumSensors-1] > cfg_i.escape_thr) begin
      left_sum  = -psc_pkg::sum_t'(psc_pkg::SpinSpeed);
      right_sum = psc_pkg::sum_t'(psc_pkg::SpinSpeed);
      escape_o  = 1'b1;
    end

    lim = psc_pkg::sum_t'({3'b000, cfg_i.limit});
    priority if (left_sum > lim)   left_c = lim;
    else if     (left_sum < -lim)  left_c = -lim;
    else                           left_c = left_sum;
    priority if (right_sum > lim)  right_c = lim;
    else if     (right_sum < -lim) right_c = -lim;
    else                           right_c = right_sum;

    left_d  = psc_pkg::speed_t'(left_c);
    right_d = psc_pkg::speed_t'(right_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
    end else if (en_i) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign left_o       = left_d;
  assign right_o      = right_d;
  assign left_wheel_o = left_q;

endmodule

// ----- hdl/psc_beat.sv -----
// Heartbeat counter and LED toggle with front-distance period scaling.
// Depends on psc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "proximity_steering_controller_defines.svh"

module psc_beat (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  psc_pkg::prox_t  front_left_i,
  input  psc_pkg::prox_t  front_right_i,
  input  psc_pkg::cfg_t   cfg_i,
  output logic            led_o
);

  psc_pkg::beat_t count_q, count_d, count_inc, period;
  logic           led_q, led_d;
  logic [47:0]    steps;

  always_comb begin
    count_inc = count_q + 24'd1;
    steps     = 48'(count_inc) * 48'(cfg_i.weight);
    priority if (front_left_i > psc_pkg::FrontHigh || front_right_i > psc_pkg::FrontHigh)
      period = cfg_i.interval_40;
    else if (front_left_i > psc_pkg::FrontLow || front_right_i > psc_pkg::FrontLow)
      period = cfg_i.interval_60;
    else
      period = cfg_i.interval;
    if (steps > 48'(period)) begin
      led_d   = ~led_q;
      count_d = '0;
    end else begin
      led_d   = led_q;
      count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      led_q   <= 1'b0;
    end else if (en_i) begin
      count_q <= count_d;
      led_q   <= led_d;
    end
  end

  assign led_o = led_d;

  `PSC_ASSERT_NXT(a_toggle_clears_count, clk_i, rst_ni, en_i && (led_d != led_q), count_q == '0, "LED toggled without clearing the beat counter")

endmodule
